// ----- src/prpc_pkg.sv -----
// Shared types, constants and codes for the priority range packet classifier.
package prpc_pkg;

  localparam int MAX_RULES = 64;
  localparam int CNT_W = $clog2(MAX_RULES + 1);

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [31:0] VERDICT_ACCEPT = 32'd1;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_CLASSIFY = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  typedef struct packed {
    logic signed [31:0] id;
    logic signed [7:0]  prio;
    logic               enabled;
    logic [15:0]        proto_span;
    logic [63:0]        src_span;
    logic [63:0]        dst_span;
    logic [63:0]        port_spans;
    logic [31:0]        result;
  } rule_t;

  typedef struct packed {
    logic [1:0]  mode;
    rule_t       new_rule;
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  proto;
  } cmd_t;

  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctrl_t;

  typedef struct packed {
    logic        ge;
    logic        kill;
    logic        found;
    logic [31:0] verdict;
  } chain_t;

endpackage

// ----- src/prpc_cell.sv -----
// One rule slot: holds a rule, shifts on insert and delete, matches packets.
module prpc_cell
  import prpc_pkg::*;
(
  input  logic       clk,
  input  cmd_t       cmd,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  rule_t      left_rule,
  input  rule_t      right_rule,
  input  chain_t     chain_in,
  output chain_t     chain_out,
  output rule_t      rule
);

  logic ge_self;
  logic match_id;
  logic hit_next;
  logic hit;
  logic port_check;

  assign ge_self  = !occupied || (rule.prio >= cmd.new_rule.prio);
  assign match_id = occupied && (rule.id == cmd.new_rule.id);
  assign port_check = (cmd.proto == PROTO_TCP) || (cmd.proto == PROTO_UDP);

  always_comb begin
    hit_next = occupied && rule.enabled
      && (cmd.proto >= rule.proto_span[15:8]) && (cmd.proto < rule.proto_span[7:0])
      && (cmd.sa >= rule.src_span[63:32]) && (cmd.sa < rule.src_span[31:0])
      && (cmd.da >= rule.dst_span[63:32]) && (cmd.da < rule.dst_span[31:0]);
    if (port_check) begin
      hit_next = hit_next
        && (cmd.sp >= rule.port_spans[63:48]) && (cmd.sp < rule.port_spans[47:32])
        && (cmd.dp >= rule.port_spans[31:16]) && (cmd.dp < rule.port_spans[15:0]);
    end
  end

  // The found flag and the verdict of the first hit ripple down the row.
  always_comb begin
    chain_out.ge    = ge_self;
    chain_out.kill  = chain_in.kill || match_id;
    chain_out.found = chain_in.found || hit;
    chain_out.verdict = chain_in.found ? chain_in.verdict :
                        (hit ? rule.result : 32'd0);
  end

  always_ff @(posedge clk) begin
    hit <= hit_next;
    if (ctrl.ins && chain_in.ge) begin
      rule <= left_rule;
    end else if (ctrl.ins && ge_self) begin
      rule <= cmd.new_rule;
    end else if (ctrl.del && chain_out.kill) begin
      rule <= right_rule;
    end
  end

endmodule

// ----- src/priority_range_packet_classifier.sv -----
// Rule table as a row of cells. Insert and clear finish in the execute state; classify
// adds a classify state (cell compare, then the first-hit ripple down the row); delete
// stays in execute while the row closes one gap per cycle. A new word can be taken at
// the edge that delivers the previous result; a stalled result stalls the input.
module priority_range_packet_classifier
  import prpc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          mode,
  input  logic signed [31:0]  rule_id,
  input  logic signed [7:0]   rule_priority,
  input  logic                rule_enabled,
  input  logic [31:0]         rule_verdict,
  input  logic [63:0]         src_addr_range,
  input  logic [63:0]         dst_addr_range,
  input  logic [63:0]         port_ranges,
  input  logic [15:0]         protocol_range,
  input  logic [63:0]         pkt_addresses,
  input  logic [31:0]         pkt_ports,
  input  logic [7:0]          pkt_protocol,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                status,
  output logic [31:0]         verdict,
  output logic                matched,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_CLS  = 3'b100
  } state_t;

  state_t           state;
  cmd_t             cmd;
  logic [CNT_W-1:0] rule_count;
  logic [31:0]      default_verdict;
  cell_ctrl_t       ctrl;
  logic             full;
  logic             accept;

  rule_t  rules  [MAX_RULES];
  chain_t chains [MAX_RULES + 1];

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE) || (out_valid && out_stall);
  assign accept    = in_valid && !in_stall;
  assign full      = (rule_count == CNT_W'(MAX_RULES));

  assign ctrl.ins = (state == S_EXEC) && (cmd.mode == MODE_INSERT) && !full;
  assign ctrl.del = (state == S_EXEC) && (cmd.mode == MODE_DELETE);

  assign chains[0] = '0;

  genvar g;
  generate
    for (g = 0; g < MAX_RULES; g++) begin : g_cell
      logic occupied;
      assign occupied = (CNT_W'(g) < rule_count);
      prpc_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .ctrl      (ctrl),
        .occupied  (occupied),
        .left_rule (rules[(g == 0) ? 0 : g - 1]),
        .right_rule(rules[(g == MAX_RULES - 1) ? g : g + 1]),
        .chain_in  (chains[g]),
        .chain_out (chains[g + 1]),
        .rule      (rules[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.mode                <= mode;
      cmd.new_rule.id         <= rule_id;
      cmd.new_rule.prio       <= rule_priority;
      cmd.new_rule.enabled    <= rule_enabled;
      cmd.new_rule.proto_span <= protocol_range;
      cmd.new_rule.src_span   <= src_addr_range;
      cmd.new_rule.dst_span   <= dst_addr_range;
      cmd.new_rule.port_spans <= port_ranges;
      cmd.new_rule.result     <= rule_verdict;
      cmd.sa    <= pkt_addresses[63:32];
      cmd.da    <= pkt_addresses[31:0];
      cmd.sp    <= pkt_ports[31:16];
      cmd.dp    <= pkt_ports[15:0];
      cmd.proto <= pkt_protocol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      rule_count      <= '0;
      default_verdict <= VERDICT_ACCEPT;
      out_valid       <= 1'b0;
      status          <= 1'b0;
      verdict         <= '0;
      matched         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        default_verdict <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cmd.mode)
            MODE_INSERT: begin
              if (!full) begin
                rule_count <= rule_count + CNT_W'(1);
              end
              status    <= full;
              verdict   <= '0;
              matched   <= 1'b0;
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end
            MODE_DELETE: begin
              // Each cycle the first matching rule is squeezed out.
              if (chains[MAX_RULES].kill) begin
                rule_count <= rule_count - CNT_W'(1);
              end else begin
                status    <= 1'b0;
                verdict   <= '0;
                matched   <= 1'b0;
                out_valid <= 1'b1;
                state     <= S_IDLE;
              end
            end
            MODE_CLASSIFY: begin
              state <= S_CLS;
            end
            default: begin
              rule_count <= '0;
              status     <= 1'b0;
              verdict    <= '0;
              matched    <= 1'b0;
              out_valid  <= 1'b1;
              state      <= S_IDLE;
            end
          endcase
        end
        S_CLS: begin
          status    <= 1'b0;
          matched   <= chains[MAX_RULES].found;
          verdict   <= chains[MAX_RULES].found ? chains[MAX_RULES].verdict
                                               : default_verdict;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rule_count <= CNT_W'(MAX_RULES))
    else $error("rule count above table size");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> !out_valid)
    else $error("result shown in the cycle after a word was taken");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && cmd.mode == MODE_INSERT && full) |=> (status && out_valid
      && $stable(rule_count)))
    else $error("insert into a full table was not refused");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the priority range packet classifier.
`timescale 1ns / 1ps

module tb
  import prpc_pkg::*;
();

  typedef struct {
    logic signed [31:0] id;
    logic signed [7:0]  prio;
    logic               enabled;
    logic [15:0]        proto_span;
    logic [63:0]        src_span;
    logic [63:0]        dst_span;
    logic [63:0]        port_spans;
    logic [31:0]        result;
  } acl_rule_t;

  typedef struct {
    logic        status;
    logic [31:0] verdict;
    logic        matched;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] mode = MODE_CLEAR;
  logic signed [31:0] rule_id = '0;
  logic signed [7:0] rule_priority = '0;
  logic rule_enabled = 1'b0;
  logic [31:0] rule_verdict = '0;
  logic [63:0] src_addr_range = '0;
  logic [63:0] dst_addr_range = '0;
  logic [63:0] port_ranges = '0;
  logic [15:0] protocol_range = '0;
  logic [63:0] pkt_addresses = '0;
  logic [31:0] pkt_ports = '0;
  logic [7:0] pkt_protocol = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic status;
  logic [31:0] verdict;
  logic matched;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  priority_range_packet_classifier dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .rule_id(rule_id), .rule_priority(rule_priority),
    .rule_enabled(rule_enabled), .rule_verdict(rule_verdict),
    .src_addr_range(src_addr_range), .dst_addr_range(dst_addr_range),
    .port_ranges(port_ranges), .protocol_range(protocol_range),
    .pkt_addresses(pkt_addresses), .pkt_ports(pkt_ports), .pkt_protocol(pkt_protocol),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .verdict(verdict), .matched(matched),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model state kept beside the block.
  acl_rule_t table_q[$];
  logic [31:0] fallback_verdict;
  answer_t answers_q[$];

  int errors = 0;
  int words_sent = 0;
  int answers_seen = 0;
  int match_hits = 0;
  int full_refusals = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 1'b0;

  function automatic bit span_hit(logic [31:0] v, logic [31:0] lo, logic [31:0] hi);
    return v >= lo && v < hi;
  endfunction

  function automatic bit rule_matches(acl_rule_t r, logic [31:0] sa, logic [31:0] da,
                                      logic [15:0] sp, logic [15:0] dp, logic [7:0] pr);
    if (!r.enabled) return 1'b0;
    if (!span_hit(32'(pr), 32'(r.proto_span[15:8]), 32'(r.proto_span[7:0]))) return 1'b0;
    if (!span_hit(sa, r.src_span[63:32], r.src_span[31:0])) return 1'b0;
    if (!span_hit(da, r.dst_span[63:32], r.dst_span[31:0])) return 1'b0;
    if (pr == PROTO_TCP || pr == PROTO_UDP) begin
      if (!span_hit(32'(sp), 32'(r.port_spans[63:48]), 32'(r.port_spans[47:32])))
        return 1'b0;
      if (!span_hit(32'(dp), 32'(r.port_spans[31:16]), 32'(r.port_spans[15:0])))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  // Applies one word to the model table and returns the answer it should give.
  function automatic answer_t classify_and_update();
    answer_t a;
    acl_rule_t r;
    int pos;
    a.status = 1'b0;
    a.verdict = '0;
    a.matched = 1'b0;
    case (mode)
      MODE_INSERT: begin
        if (table_q.size() >= MAX_RULES) begin
          a.status = 1'b1;
        end else begin
          r.id = rule_id; r.prio = rule_priority; r.enabled = rule_enabled;
          r.proto_span = protocol_range; r.src_span = src_addr_range;
          r.dst_span = dst_addr_range; r.port_spans = port_ranges; r.result = rule_verdict;
          pos = 0;
          while (pos < table_q.size() && rule_priority > table_q[pos].prio) pos++;
          table_q.insert(pos, r);
        end
      end
      MODE_DELETE: begin
        for (int i = table_q.size() - 1; i >= 0; i--)
          if (table_q[i].id == rule_id) table_q.delete(i);
      end
      MODE_CLASSIFY: begin
        a.verdict = fallback_verdict;
        foreach (table_q[i]) begin
          if (rule_matches(table_q[i], pkt_addresses[63:32], pkt_addresses[31:0],
                           pkt_ports[31:16], pkt_ports[15:0], pkt_protocol)) begin
            a.verdict = table_q[i].result;
            a.matched = 1'b1;
            break;
          end
        end
      end
      default: table_q.delete();
    endcase
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  // Predict on acceptance, check on delivery.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) answers_q.push_back(classify_and_update());
      if (out_valid && !out_stall) begin
        answers_seen++;
        if (answers_q.size() == 0) begin
          report_mismatch("unexpected result", verdict, 0);
        end else begin
          answer_t e;
          e = answers_q.pop_front();
          if (status !== e.status) report_mismatch("status", 32'(status), 32'(e.status));
          if (verdict !== e.verdict) report_mismatch("verdict", verdict, e.verdict);
          if (matched !== e.matched)
            report_mismatch("matched", 32'(matched), 32'(e.matched));
          if (e.matched) match_hits++;
          if (e.status) full_refusals++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Leaves valid high on return; the next word or drain() takes it over.
  task automatic send_word(logic [1:0] m, logic signed [31:0] id, logic signed [7:0] pr,
                           logic en, logic [31:0] vd, logic [63:0] sr, logic [63:0] dr,
                           logic [63:0] pts, logic [15:0] prr, logic [63:0] pa,
                           logic [31:0] pp, logic [7:0] pk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m; rule_id <= id; rule_priority <= pr; rule_enabled <= en;
    rule_verdict <= vd; src_addr_range <= sr; dst_addr_range <= dr;
    port_ranges <= pts; protocol_range <= prr; pkt_addresses <= pa;
    pkt_ports <= pp; pkt_protocol <= pk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (answers_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_default(logic [31:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    fallback_verdict = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand_span64();
    logic [31:0] lo;
    lo = $urandom_range(0, 200);
    return {lo, lo + 32'($urandom_range(0, 120))};
  endfunction

  task automatic send_random_rule(int id_pool);
    logic [7:0] pb;
    logic [15:0] a, b;
    pb = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
    a = 16'($urandom_range(0, 300));
    b = 16'($urandom_range(0, 300));
    send_word(MODE_INSERT, $urandom_range(0, id_pool), 8'($urandom), $urandom_range(9) != 0,
              $urandom, ($urandom_range(9) == 0) ? {$urandom, $urandom} : rand_span64(),
              rand_span64(),
              {a, a + 16'($urandom_range(0, 150)), b, b + 16'($urandom_range(0, 150))},
              {pb, pb + 8'($urandom_range(0, 12))}, {$urandom, $urandom}, $urandom,
              8'($urandom));
  endtask

  task automatic send_random_packet();
    logic [7:0] pk;
    case ($urandom_range(3))
      0: pk = PROTO_TCP;
      1: pk = PROTO_UDP;
      2: pk = 8'($urandom_range(0, 25));
      default: pk = 8'($urandom);
    endcase
    send_word(MODE_CLASSIFY, $urandom, 8'($urandom), 1'($urandom), $urandom,
              {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              16'($urandom),
              ($urandom_range(7) == 0) ? {$urandom, $urandom}
                : {32'($urandom_range(0, 330)), 32'($urandom_range(0, 330))},
              ($urandom_range(7) == 0) ? $urandom
                : {16'($urandom_range(0, 460)), 16'($urandom_range(0, 460))}, pk);
  endtask

  task automatic test_directed();
    logic [63:0] all = {32'd0, 32'hFFFFFFFF};
    logic [63:0] allp = {16'd0, 16'hFFFF, 16'd0, 16'hFFFF};
    send_word(MODE_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, PROTO_TCP);
    send_word(MODE_INSERT, 32'sh7FFFFFFF, 8'sh7F, 1, 32'hFFFFFFFF, all, all, allp,
              16'h00FF, 0, 0, 0);
    send_word(MODE_INSERT, 32'sh80000000, 8'sh80, 1, 32'hA5A5A5A5,
              {32'd10, 32'd20}, all, {16'd80, 16'd81, 16'd0, 16'hFFFF}, {8'd6, 8'd7},
              0, 0, 0);
    send_word(MODE_INSERT, 5, 8'sh80, 1, 32'h55, {32'd5, 32'd5}, all, allp, 16'h00FF,
              0, 0, 0);
    send_word(MODE_INSERT, 6, 0, 0, 32'h66, all, all, allp, 16'h00FF, 0, 0, 0);
    send_word(MODE_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 0, {32'd15, 32'd1}, {16'd80, 16'd9},
              PROTO_TCP);
    send_word(MODE_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 0, {32'd15, 32'd1}, {16'd81, 16'd9},
              PROTO_TCP);
    send_word(MODE_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 0, {32'hFFFFFFFF, 32'hFFFFFFFF},
              32'hFFFFFFFF, PROTO_UDP);
    send_word(MODE_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'hFF);
    send_word(MODE_DELETE, 32'sh80000000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(MODE_DELETE, 12345, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(MODE_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 0, {32'd15, 32'd1}, {16'd80, 16'd9},
              PROTO_TCP);
    for (int i = 0; i < MAX_RULES; i++)
      send_word(MODE_INSERT, 7, 8'(i), 1, i, all, all, allp, 16'h00FF, 0, 0, 0);
    send_word(MODE_INSERT, 8, 0, 1, 0, all, all, allp, 16'h00FF, 0, 0, 0);
    send_word(MODE_DELETE, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(MODE_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, PROTO_UDP);
  endtask

  task automatic test_random_phase(int items, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < items; i++) begin
      int r = $urandom_range(99);
      if (r < 40) send_random_rule(40);
      else if (r < 88) send_random_packet();
      else if (r < 97) send_word(MODE_DELETE, $urandom_range(0, 40), 8'($urandom),
                                 1'($urandom), $urandom, 0, 0, 0, 0, 0, 0, 0);
      else send_word(MODE_CLEAR, $urandom, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_back_pressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 30; i++) send_random_packet();
    join
    drain();
    for (int i = 0; i < 20; i++) send_random_rule(10);
  endtask

  initial begin
    fallback_verdict = VERDICT_ACCEPT;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    write_default(32'h0);
    test_random_phase(400, 0, 0);
    write_default(32'hFFFFFFFF);
    test_random_phase(400, 77, 0);
    write_default(32'h12345678);
    test_random_phase(400, 0, 77);
    write_default(VERDICT_ACCEPT);
    test_random_phase(350, 32, 32);
    test_back_pressure();
    drain();
    repeat (20) @(negedge clk);
    $display("Sent %0d words, checked %0d results (%0d rule hits, %0d full-table refusals)",
             words_sent, answers_seen, match_hits, full_refusals);
    $display("Four default verdicts and four idle/stall mixes were exercised.");
    if (errors == 0 && answers_q.size() == 0) begin
      $display("PASS priority_range_packet_classifier");
    end else begin
      $display("FAIL priority_range_packet_classifier");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL priority_range_packet_classifier");
    $finish;
  end

endmodule
